### rtl/hbs_pkg.sv
`timescale 1ns / 1ps

package hbs_pkg;

  // Field widths of the request and result ports.
  localparam int IDX_W     = 14;
  localparam int VAL_W     = 16;
  localparam int POS_W     = 16;
  localparam int OUT_W     = 16;
  localparam int CFG_W     = 8;
  localparam int CFG_IDX_W = 1;

  // Default sizes for the top level parameters.
  localparam int DEF_MAX_COLUMNS   = 128;
  localparam int DEF_MAX_ROWS      = 128;
  localparam int DEF_HEIGHT_BITS   = 16;
  localparam int DEF_FRACTION_BITS = 12;

  // World square is -WORLD_HALF..WORLD_HALF, WORLD_SPAN wide.
  localparam int WORLD_HALF = 5;
  localparam int WORLD_SPAN = 10;

  // Reset value of both grid size registers.
  localparam logic [CFG_W-1:0] GRID_RESET = 8'd128;

  // Request action codes.
  localparam logic ACT_LOAD  = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT = 1'b1;

endpackage

### rtl/heightmap_bilinear_sampler_unit.sv
`timescale 1ns / 1ps
// Heightmap bilinear sampler. A load request (in_action = 0) writes one grid height and gives
// no result; a query request (in_action = 1) gives exactly one result, on out_strobe. One
// request is taken in every cycle and busy stays low, since results are never held off: the
// rate of one request per cycle comes from the grid store being split by address parity into
// two banks that each read two addresses per cycle, so all four corners arrive together.
// Loads and queries reach the store in request order, so a query sees every load taken
// before it. The store is not cleared at reset; a query must only touch entries that were
// loaded. Grid size registers must be written only while no query is in flight; the block
// itself does not enforce this.

module heightmap_bilinear_sampler_unit
  import hbs_pkg::*;
#(
  parameter int MAX_COLUMNS   = DEF_MAX_COLUMNS,
  parameter int MAX_ROWS      = DEF_MAX_ROWS,
  parameter int HEIGHT_BITS   = DEF_HEIGHT_BITS,
  parameter int FRACTION_BITS = DEF_FRACTION_BITS
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  output logic                    busy,
  input  logic                    in_action,
  input  logic [IDX_W-1:0]        in_sample_index,
  input  logic [VAL_W-1:0]        in_sample_value,
  input  logic signed [POS_W-1:0] in_pos_x,
  input  logic signed [POS_W-1:0] in_pos_y,
  output logic                    out_strobe,
  output logic [OUT_W-1:0]        out_terrain_height,
  output logic                    out_on_terrain,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_W-1:0]        cfg_data
);

  localparam int HB      = HEIGHT_BITS;
  localparam int FB      = FRACTION_BITS;
  localparam int DEPTH   = MAX_COLUMNS * MAX_ROWS;
  localparam int ADDR_W  = $clog2(DEPTH);
  localparam int AW1     = ADDR_W + 1;
  localparam int BANK_DEPTH = (DEPTH + 1) / 2;
  localparam int BANK_AW = $clog2(BANK_DEPTH);
  localparam int LD_W    = (IDX_W > AW1) ? IDX_W : AW1;
  localparam int MAX_DIM = (MAX_COLUMNS > MAX_ROWS) ? MAX_COLUMNS : MAX_ROWS;
  localparam int SZ_W    = $clog2(MAX_DIM);
  localparam int DIM_W   = (CFG_W > $clog2(MAX_DIM + 1)) ? CFG_W : $clog2(MAX_DIM + 1);
  localparam int COL_W   = $clog2(MAX_COLUMNS + 1);
  localparam int OFF_MAX = (2 ** (POS_W - 1)) - 1 + WORLD_HALF * (2 ** FB);
  localparam int OFF_W   = $clog2(OFF_MAX + 1);
  localparam int SOFF_W  = OFF_W + 1;
  localparam int PROD_W  = OFF_W + SZ_W;
  localparam int RECIP_SHIFT = PROD_W + 3;
  localparam int T_W     = PROD_W - 3;
  localparam int LM_W    = HB + FB + 2;

  // Reciprocal of the world span, exact for every product below 2^PROD_W.
  localparam logic [63:0] RECIP_WIDE =
    ((64'd1 << RECIP_SHIFT) + 64'(WORLD_SPAN - 1)) / WORLD_SPAN;
  localparam logic [PROD_W-1:0] RECIP = RECIP_WIDE[PROD_W-1:0];
  localparam logic [SOFF_W-1:0] HALF_OFF = SOFF_W'(WORLD_HALF) << FB;
  localparam logic [LD_W-1:0]   DEPTH_LIM = LD_W'(DEPTH);

  typedef struct packed {
    logic               en;
    logic               bank;
    logic [BANK_AW-1:0] addr;
    logic [HB-1:0]      data;
  } ld_t;

  // The pipeline never stalls, so requests and configuration writes are always taken.
  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  // Configuration registers.
  logic [CFG_W-1:0] grid_width_r;
  logic [CFG_W-1:0] grid_height_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_width_r  <= GRID_RESET;
      grid_height_r <= GRID_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_GRID_WIDTH:  grid_width_r  <= cfg_data;
        CFG_GRID_HEIGHT: grid_height_r <= cfg_data;
      endcase
    end
  end

  // Clamp the grid sizes to the supported range.
  logic [DIM_W-1:0] gw_ext, gh_ext, cols_c, rows_c;
  logic [SZ_W-1:0]  cols_m1, rows_m1;
  logic [COL_W-1:0] cols_w;

  always_comb begin
    gw_ext = DIM_W'(grid_width_r);
    gh_ext = DIM_W'(grid_height_r);
    if (gw_ext < DIM_W'(2)) begin
      cols_c = DIM_W'(2);
    end else if (gw_ext > DIM_W'(MAX_COLUMNS)) begin
      cols_c = DIM_W'(MAX_COLUMNS);
    end else begin
      cols_c = gw_ext;
    end
    if (gh_ext < DIM_W'(2)) begin
      rows_c = DIM_W'(2);
    end else if (gh_ext > DIM_W'(MAX_ROWS)) begin
      rows_c = DIM_W'(MAX_ROWS);
    end else begin
      rows_c = gh_ext;
    end
    cols_m1 = SZ_W'(cols_c - DIM_W'(1));
    rows_m1 = SZ_W'(rows_c - DIM_W'(1));
    cols_w  = COL_W'(cols_c);
  end

  // Stage 1: decode the request and shift positions by WORLD_HALF, so the world square maps to 0..10.
  logic                     accept;
  logic [LD_W-1:0]          ld_idx;
  logic [HB+VAL_W-1:0]      ld_val_ext;
  logic [SOFF_W-1:0]        s1_off_x_nxt, s1_off_y_nxt;
  ld_t                      s1_ld_nxt;

  assign accept     = start && !busy;
  assign ld_idx     = LD_W'(in_sample_index);
  assign ld_val_ext = {{HB{1'b0}}, in_sample_value};

  always_comb begin
    s1_off_x_nxt   = {{(SOFF_W - POS_W){in_pos_x[POS_W-1]}}, in_pos_x} + HALF_OFF;
    s1_off_y_nxt   = {{(SOFF_W - POS_W){in_pos_y[POS_W-1]}}, in_pos_y} + HALF_OFF;
    s1_ld_nxt.en   = accept && (in_action == ACT_LOAD) && (ld_idx < DEPTH_LIM);
    s1_ld_nxt.bank = ld_idx[0];
    s1_ld_nxt.addr = ld_idx[BANK_AW:1];
    s1_ld_nxt.data = ld_val_ext[HB-1:0];
  end

  logic               s1_qv_r;
  ld_t                s1_ld_r;
  logic               s1_neg_x_r, s1_neg_y_r;
  logic [OFF_W-1:0]   s1_mag_x_r, s1_mag_y_r;

  // Stage 2: scale by grid size minus one.
  logic [PROD_W-1:0]  s2_px_nxt, s2_py_nxt;
  assign s2_px_nxt = s1_mag_x_r * cols_m1;
  assign s2_py_nxt = s1_mag_y_r * rows_m1;

  logic               s2_qv_r;
  ld_t                s2_ld_r;
  logic               s2_neg_x_r, s2_neg_y_r;
  logic [PROD_W-1:0]  s2_px_r, s2_py_r;

  // Stage 3: divide by the world span through the reciprocal.
  logic [2*PROD_W-1:0] s3_qx_full, s3_qy_full;
  assign s3_qx_full = s2_px_r * RECIP;
  assign s3_qy_full = s2_py_r * RECIP;

  logic               s3_qv_r;
  ld_t                s3_ld_r;
  logic               s3_neg_x_r, s3_neg_y_r;
  logic [T_W-1:0]     s3_tx_r, s3_ty_r;

  // Stage 4: range check, split into cell and weight, row base address.
  logic [T_W-1:0]         lim_x, lim_y;
  logic                   s4_on_nxt;
  logic [SZ_W-1:0]        s4_cx_nxt, s4_cy_nxt;
  logic [SZ_W+COL_W-1:0]  s4_rb_full;

  always_comb begin
    lim_x      = T_W'({cols_m1, {FB{1'b0}}});
    lim_y      = T_W'({rows_m1, {FB{1'b0}}});
    s4_on_nxt  = !s3_neg_x_r && !s3_neg_y_r && (s3_tx_r < lim_x) && (s3_ty_r < lim_y);
    s4_cx_nxt  = s3_tx_r[FB+SZ_W-1:FB];
    s4_cy_nxt  = s3_ty_r[FB+SZ_W-1:FB];
    s4_rb_full = s4_cy_nxt * cols_w;
  end

  logic               s4_qv_r;
  ld_t                s4_ld_r;
  logic               s4_on_r;
  logic [AW1-1:0]     s4_rb_r;
  logic [SZ_W-1:0]    s4_cx_r;
  logic [FB-1:0]      s4_wx_r, s4_wy_r;

  // Corner addresses; the even bank takes (a+1)/2, the odd bank a/2.
  logic [AW1-1:0]     addr_a, addr_b, addr_a1, addr_b1;
  logic [BANK_AW-1:0] even_ia, even_ib, odd_ia, odd_ib;

  always_comb begin
    addr_a  = s4_rb_r + AW1'(s4_cx_r);
    addr_b  = addr_a + AW1'(cols_w);
    addr_a1 = addr_a + AW1'(1);
    addr_b1 = addr_b + AW1'(1);
    even_ia = addr_a1[BANK_AW:1];
    even_ib = addr_b1[BANK_AW:1];
    odd_ia  = addr_a[BANK_AW:1];
    odd_ib  = addr_b[BANK_AW:1];
  end

  // Grid store, banked by address parity. Loads write here in request order.
  logic [HB-1:0] even_mem [BANK_DEPTH];
  logic [HB-1:0] odd_mem  [BANK_DEPTH];
  logic [HB-1:0] even_rd_a_r, even_rd_b_r, odd_rd_a_r, odd_rd_b_r;

  always_ff @(posedge clk) begin
    if (s4_ld_r.en && !s4_ld_r.bank) begin
      even_mem[s4_ld_r.addr] <= s4_ld_r.data;
    end
    if (s4_qv_r) begin
      even_rd_a_r <= even_mem[even_ia];
      even_rd_b_r <= even_mem[even_ib];
    end
  end

  always_ff @(posedge clk) begin
    if (s4_ld_r.en && s4_ld_r.bank) begin
      odd_mem[s4_ld_r.addr] <= s4_ld_r.data;
    end
    if (s4_qv_r) begin
      odd_rd_a_r <= odd_mem[odd_ia];
      odd_rd_b_r <= odd_mem[odd_ib];
    end
  end

  logic               s5_qv_r;
  logic               s5_on_r;
  logic               s5_apar_r, s5_bpar_r;
  logic [FB-1:0]      s5_wx_r, s5_wy_r;

  // Stage 5 to 6: sort the corners and start both row blends.
  logic [HB-1:0]        z1, z2, z3, z4;
  logic signed [HB:0]   d1, d2;
  logic signed [LM_W-1:0] s6_m1_nxt, s6_m2_nxt;

  always_comb begin
    z1 = s5_apar_r ? odd_rd_a_r  : even_rd_a_r;
    z2 = s5_apar_r ? even_rd_a_r : odd_rd_a_r;
    z3 = s5_bpar_r ? odd_rd_b_r  : even_rd_b_r;
    z4 = s5_bpar_r ? even_rd_b_r : odd_rd_b_r;
    d1 = $signed({1'b0, z2}) - $signed({1'b0, z1});
    d2 = $signed({1'b0, z4}) - $signed({1'b0, z3});
    s6_m1_nxt = d1 * $signed({1'b0, s5_wx_r});
    s6_m2_nxt = d2 * $signed({1'b0, s5_wx_r});
  end

  logic                   s6_qv_r;
  logic                   s6_on_r;
  logic [FB-1:0]          s6_wy_r;
  logic [HB-1:0]          s6_z1_r, s6_z3_r;
  logic signed [LM_W-1:0] s6_m1_r, s6_m2_r;

  // Stage 6 to 7: finish the row blends; the shift is a floor.
  logic [HB:0] sum1, sum2;
  always_comb begin
    sum1 = {1'b0, s6_z1_r} + s6_m1_r[HB+FB:FB];
    sum2 = {1'b0, s6_z3_r} + s6_m2_r[HB+FB:FB];
  end

  logic               s7_qv_r;
  logic               s7_on_r;
  logic [FB-1:0]      s7_wy_r;
  logic [HB-1:0]      s7_r1_r, s7_r2_r;

  // Stage 7 to 8: column blend product.
  logic signed [HB:0]     d3;
  logic signed [LM_W-1:0] s8_m3_nxt;
  always_comb begin
    d3        = $signed({1'b0, s7_r2_r}) - $signed({1'b0, s7_r1_r});
    s8_m3_nxt = d3 * $signed({1'b0, s7_wy_r});
  end

  logic                   s8_qv_r;
  logic                   s8_on_r;
  logic [HB-1:0]          s8_r1_r;
  logic signed [LM_W-1:0] s8_m3_r;

  // Stage 8 to output: finish the column blend, zero off the terrain.
  logic [HB:0]          sum3;
  logic [HB+OUT_W-1:0]  z_ext;
  logic [OUT_W-1:0]     out_height_nxt;
  always_comb begin
    sum3           = {1'b0, s8_r1_r} + s8_m3_r[HB+FB:FB];
    z_ext          = {{OUT_W{1'b0}}, sum3[HB-1:0]};
    out_height_nxt = s8_on_r ? z_ext[OUT_W-1:0] : '0;
  end

  logic             out_strobe_r;
  logic             out_on_r;
  logic [OUT_W-1:0] out_height_r;

  // Control state of every stage.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_qv_r      <= 1'b0;
      s1_ld_r      <= '0;
      s2_qv_r      <= 1'b0;
      s2_ld_r      <= '0;
      s3_qv_r      <= 1'b0;
      s3_ld_r      <= '0;
      s4_qv_r      <= 1'b0;
      s4_ld_r      <= '0;
      s5_qv_r      <= 1'b0;
      s6_qv_r      <= 1'b0;
      s7_qv_r      <= 1'b0;
      s8_qv_r      <= 1'b0;
      out_strobe_r <= 1'b0;
      out_on_r     <= 1'b0;
    end else begin
      s1_qv_r      <= accept && (in_action == ACT_QUERY);
      s1_ld_r      <= s1_ld_nxt;
      s2_qv_r      <= s1_qv_r;
      s2_ld_r      <= s1_ld_r;
      s3_qv_r      <= s2_qv_r;
      s3_ld_r      <= s2_ld_r;
      s4_qv_r      <= s3_qv_r;
      s4_ld_r      <= s3_ld_r;
      s5_qv_r      <= s4_qv_r;
      s6_qv_r      <= s5_qv_r;
      s7_qv_r      <= s6_qv_r;
      s8_qv_r      <= s7_qv_r;
      out_strobe_r <= s8_qv_r;
      out_on_r     <= s8_qv_r && s8_on_r;
    end
  end

  // Data registers of every stage.
  always_ff @(posedge clk) begin
    s1_neg_x_r   <= s1_off_x_nxt[SOFF_W-1];
    s1_neg_y_r   <= s1_off_y_nxt[SOFF_W-1];
    s1_mag_x_r   <= s1_off_x_nxt[OFF_W-1:0];
    s1_mag_y_r   <= s1_off_y_nxt[OFF_W-1:0];
    s2_neg_x_r   <= s1_neg_x_r;
    s2_neg_y_r   <= s1_neg_y_r;
    s2_px_r      <= s2_px_nxt;
    s2_py_r      <= s2_py_nxt;
    s3_neg_x_r   <= s2_neg_x_r;
    s3_neg_y_r   <= s2_neg_y_r;
    s3_tx_r      <= s3_qx_full[2*PROD_W-1:RECIP_SHIFT];
    s3_ty_r      <= s3_qy_full[2*PROD_W-1:RECIP_SHIFT];
    s4_on_r      <= s4_on_nxt;
    s4_rb_r      <= AW1'(s4_rb_full);
    s4_cx_r      <= s4_cx_nxt;
    s4_wx_r      <= s3_tx_r[FB-1:0];
    s4_wy_r      <= s3_ty_r[FB-1:0];
    s5_on_r      <= s4_on_r;
    s5_apar_r    <= addr_a[0];
    s5_bpar_r    <= addr_b[0];
    s5_wx_r      <= s4_wx_r;
    s5_wy_r      <= s4_wy_r;
    s6_on_r      <= s5_on_r;
    s6_wy_r      <= s5_wy_r;
    s6_z1_r      <= z1;
    s6_z3_r      <= z3;
    s6_m1_r      <= s6_m1_nxt;
    s6_m2_r      <= s6_m2_nxt;
    s7_on_r      <= s6_on_r;
    s7_wy_r      <= s6_wy_r;
    s7_r1_r      <= sum1[HB-1:0];
    s7_r2_r      <= sum2[HB-1:0];
    s8_on_r      <= s7_on_r;
    s8_r1_r      <= s7_r1_r;
    s8_m3_r      <= s8_m3_nxt;
    out_height_r <= out_height_nxt;
  end

  assign out_strobe         = out_strobe_r;
  assign out_on_terrain     = out_on_r;
  assign out_terrain_height = out_height_r;

  // Every result comes from a query that was taken at the input.
  a_strobe_from_query: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(start && !busy && (in_action == ACT_QUERY), 9))
    else $error("result without a matching query");

  // Every query taken gives its result on out_strobe.
  a_query_gives_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_action == ACT_QUERY)) |-> ##9 out_strobe)
    else $error("query lost in the pipeline");

  // A store write and a store read never share a cycle.
  a_store_port_excl: assert property (@(posedge clk) disable iff (!rst_n)
    s4_ld_r.en |-> !s4_qv_r)
    else $error("load and query at the store together");

  // The on-terrain flag only appears with a result.
  a_on_needs_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_on_terrain |-> out_strobe)
    else $error("on_terrain without a result");

endmodule

### verif/heightmap_bilinear_sampler_unit_tb.sv
`timescale 1ns / 1ps

module heightmap_bilinear_sampler_unit_tb;
  import hbs_pkg::*;

  localparam int STORE_DEPTH  = DEF_MAX_COLUMNS * DEF_MAX_ROWS;
  localparam int FRAC         = DEF_FRACTION_BITS;
  localparam int HALF_Q       = WORLD_HALF << FRAC;
  localparam int SPAN_Q       = WORLD_SPAN << FRAC;
  localparam int DRAIN_CYCLES = 12;
  localparam int PHASE_ITEMS  = 150;
  localparam int NUM_PHASES   = 9;
  localparam int CYCLE_LIMIT  = 300000;

  typedef struct packed {
    logic [OUT_W-1:0] height;
    logic             on_terrain;
  } terrain_t;

  typedef struct {
    logic                    act;
    logic [IDX_W-1:0]        idx;
    logic [VAL_W-1:0]        val;
    logic signed [POS_W-1:0] px;
    logic signed [POS_W-1:0] py;
    bit                      typed;
    terrain_t                want;
  } dir_row_t;

  logic                    clk;
  logic                    rst_n;
  logic                    start;
  logic                    busy;
  logic                    in_action;
  logic [IDX_W-1:0]        in_sample_index;
  logic [VAL_W-1:0]        in_sample_value;
  logic signed [POS_W-1:0] in_pos_x;
  logic signed [POS_W-1:0] in_pos_y;
  logic                    out_strobe;
  logic [OUT_W-1:0]        out_terrain_height;
  logic                    out_on_terrain;
  logic                    cfg_valid;
  logic                    cfg_ready;
  logic [CFG_IDX_W-1:0]    cfg_index;
  logic [CFG_W-1:0]        cfg_data;

  // Mirror of the grid and the size registers, updated as requests are taken.
  logic [VAL_W-1:0] grid_heights [STORE_DEPTH];
  bit               grid_loaded  [STORE_DEPTH];
  logic [CFG_W-1:0] grid_width_reg;
  logic [CFG_W-1:0] grid_height_reg;

  terrain_t pending_heights [$];
  dir_row_t directed_rows [$];
  int       errors;
  int       items_sent;
  int       burst_left;
  int       cycles;

  logic [CFG_W-1:0] phase_widths  [NUM_PHASES] = '{128, 2, 0, 255, 128, 1, 37, 200, 0};
  logic [CFG_W-1:0] phase_heights [NUM_PHASES] = '{128, 2, 1, 255, 2, 129, 90, 128, 0};

  heightmap_bilinear_sampler_unit i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_action         (in_action),
    .in_sample_index   (in_sample_index),
    .in_sample_value   (in_sample_value),
    .in_pos_x          (in_pos_x),
    .in_pos_y          (in_pos_y),
    .out_strobe        (out_strobe),
    .out_terrain_height(out_terrain_height),
    .out_on_terrain    (out_on_terrain),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Sizes below two or above the store dimension are clamped by the block.
  function automatic int grid_size(input logic [CFG_W-1:0] v, input int hi);
    if (v < 2) return 2;
    if (v > hi) return hi;
    return int'(v);
  endfunction

  function automatic longint floor_div_span(input longint n);
    if (n >= 0) return n / WORLD_SPAN;
    return -((-n + WORLD_SPAN - 1) / WORLD_SPAN);
  endfunction

  // Maps a world position to a fixed point grid coordinate; true when inside the interior.
  function automatic bit grid_coord(input logic signed [POS_W-1:0] pos, input int size,
                                    output longint t);
    longint off;
    off = longint'(pos) + longint'(HALF_Q);
    t = floor_div_span(off * longint'(size - 1));
    return (t >= 0) && (t < (longint'(size - 1) << FRAC));
  endfunction

  function automatic int corner_addr(input longint tx, input longint ty, input int w,
                                     input int dx, input int dy);
    return int'((ty >>> FRAC) + dy) * w + int'((tx >>> FRAC) + dx);
  endfunction

  // Linear blend with the product floored by an arithmetic shift.
  function automatic longint blend(input longint a, input longint b, input longint wt);
    return a + (((b - a) * wt) >>> FRAC);
  endfunction

  function automatic terrain_t sample_terrain(input logic signed [POS_W-1:0] px,
                                              input logic signed [POS_W-1:0] py);
    int       w;
    int       h;
    longint   tx;
    longint   ty;
    longint   fmask;
    longint   row_lo;
    longint   row_hi;
    longint   z;
    bit       inx;
    bit       iny;
    terrain_t res;
    w = grid_size(grid_width_reg, DEF_MAX_COLUMNS);
    h = grid_size(grid_height_reg, DEF_MAX_ROWS);
    inx = grid_coord(px, w, tx);
    iny = grid_coord(py, h, ty);
    res = '0;
    if (!(inx && iny)) return res;
    fmask = (longint'(1) << FRAC) - 1;
    row_lo = blend(longint'(grid_heights[corner_addr(tx, ty, w, 0, 0)]),
                   longint'(grid_heights[corner_addr(tx, ty, w, 1, 0)]), tx & fmask);
    row_hi = blend(longint'(grid_heights[corner_addr(tx, ty, w, 0, 1)]),
                   longint'(grid_heights[corner_addr(tx, ty, w, 1, 1)]), tx & fmask);
    z = blend(row_lo, row_hi, ty & fmask);
    res.height = z[OUT_W-1:0];
    res.on_terrain = 1'b1;
    return res;
  endfunction

  // A position inside the interior, now and then exactly on a grid line.
  function automatic logic [POS_W-1:0] interior_pos(input int size);
    int c;
    int v;
    v = int'($urandom_range(0, SPAN_Q - 1)) - HALF_Q;
    if ($urandom_range(0, 5) == 0) begin
      c = $urandom_range(0, size - 2);
      if ((SPAN_Q * c) % (size - 1) == 0) v = SPAN_Q * c / (size - 1) - HALF_Q;
    end
    return v[POS_W-1:0];
  endfunction

  // Positions at and around the edges of the world square, or anywhere.
  function automatic logic [POS_W-1:0] stray_pos();
    int v;
    case ($urandom_range(0, 7))
      0: v = -HALF_Q - 1;
      1: v = -HALF_Q;
      2: v = HALF_Q - 1;
      3: v = HALF_Q;
      4: v = -32768;
      5: v = 32767;
      default: v = $urandom;
    endcase
    return v[POS_W-1:0];
  endfunction

  task automatic add_row(input logic act, input int idx, input int val, input int px,
                         input int py, input bit typed, input int height, input bit on_t);
    dir_row_t row;
    row.act = act;
    row.idx = idx[IDX_W-1:0];
    row.val = val[VAL_W-1:0];
    row.px = px[POS_W-1:0];
    row.py = py[POS_W-1:0];
    row.typed = typed;
    row.want.height = height[OUT_W-1:0];
    row.want.on_terrain = on_t;
    directed_rows.push_back(row);
  endtask

  // Drives one request in bursts with random gaps and records its effect once taken.
  task automatic send_request(input logic act, input logic [IDX_W-1:0] idx,
                              input logic [VAL_W-1:0] val,
                              input logic signed [POS_W-1:0] px,
                              input logic signed [POS_W-1:0] py,
                              input bit typed, input terrain_t typed_result);
    int gap;
    @(negedge clk);
    if (burst_left == 0) begin
      gap = $urandom_range(1, 6);
      start <= 1'b0;
      repeat (gap) @(negedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 10);
    end
    burst_left--;
    start <= 1'b1;
    in_action <= act;
    in_sample_index <= idx;
    in_sample_value <= val;
    in_pos_x <= px;
    in_pos_y <= py;
    do @(posedge clk); while (busy);
    items_sent++;
    if (act == ACT_LOAD) begin
      grid_heights[idx] = val;
      grid_loaded[idx] = 1'b1;
    end else begin
      pending_heights.push_back(typed ? typed_result : sample_terrain(px, py));
    end
  endtask

  // Holds off new requests until every query has answered and the loads have settled.
  task automatic drain_results();
    @(negedge clk);
    start <= 1'b0;
    while (pending_heights.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_config(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_GRID_WIDTH) grid_width_reg = data;
    else grid_height_reg = data;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic load_random(input logic [IDX_W-1:0] idx);
    logic [VAL_W-1:0] val;
    case ($urandom_range(0, 4))
      0: val = '0;
      1: val = '1;
      default: val = VAL_W'($urandom);
    endcase
    send_request(ACT_LOAD, idx, val, POS_W'($urandom), POS_W'($urandom), 1'b0, '0);
  endtask

  // A query preceded by loads of any corner it reads that holds no height yet, and at random of others.
  task automatic query_at(input logic signed [POS_W-1:0] px,
                          input logic signed [POS_W-1:0] py);
    int     w;
    int     h;
    int     a;
    longint tx;
    longint ty;
    w = grid_size(grid_width_reg, DEF_MAX_COLUMNS);
    h = grid_size(grid_height_reg, DEF_MAX_ROWS);
    if (grid_coord(px, w, tx) && grid_coord(py, h, ty)) begin
      for (int dy = 0; dy < 2; dy++) begin
        for (int dx = 0; dx < 2; dx++) begin
          a = corner_addr(tx, ty, w, dx, dy);
          if (!grid_loaded[a] || $urandom_range(0, 3) == 0) load_random(a[IDX_W-1:0]);
        end
      end
    end
    send_request(ACT_QUERY, IDX_W'($urandom), VAL_W'($urandom), px, py, 1'b0, '0);
  endtask

  // Every strobed result is matched against the oldest expected height.
  always @(posedge clk) begin : result_check
    terrain_t want;
    if (rst_n && out_strobe) begin
      if (pending_heights.size() == 0) begin
        errors++;
        $display("%0t: unexpected result height %h on_terrain %b", $time,
                 out_terrain_height, out_on_terrain);
      end else begin
        want = pending_heights.pop_front();
        if (out_terrain_height !== want.height) begin
          errors++;
          $display("%0t: terrain_height expected %h actual %h", $time, want.height,
                   out_terrain_height);
        end
        if (out_on_terrain !== want.on_terrain) begin
          errors++;
          $display("%0t: on_terrain expected %b actual %b", $time, want.on_terrain,
                   out_on_terrain);
        end
      end
    end
  end

  // Guard against a hung handshake.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("** heightmap_bilinear_sampler_unit: FAILED **");
      $finish;
    end
  end

  initial begin : stimulus
    int       phase_end;
    int       w_use;
    int       h_use;
    dir_row_t row;
    start = 1'b0;
    in_action = ACT_LOAD;
    in_sample_index = '0;
    in_sample_value = '0;
    in_pos_x = '0;
    in_pos_y = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_GRID_WIDTH;
    cfg_data = '0;
    rst_n = 1'b0;
    errors = 0;
    items_sent = 0;
    burst_left = 0;
    cycles = 0;
    grid_width_reg = GRID_RESET;
    grid_height_reg = GRID_RESET;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed requests on the reset grid: corner cell, far corner cell and the edges.
    add_row(ACT_LOAD, 0, 'hFFFF, 0, 0, 1'b0, 0, 1'b0);
    add_row(ACT_LOAD, 1, 'h0000, 0, 0, 1'b0, 0, 1'b0);
    add_row(ACT_LOAD, 128, 'h1234, 0, 0, 1'b0, 0, 1'b0);
    add_row(ACT_LOAD, 129, 'hABCD, 0, 0, 1'b0, 0, 1'b0);
    // On an exact grid line the near corner's height comes back.
    add_row(ACT_QUERY, 0, 0, -HALF_Q, -HALF_Q, 1'b1, 'hFFFF, 1'b1);
    add_row(ACT_QUERY, 0, 0, -32768, -32768, 1'b1, 0, 1'b0);
    add_row(ACT_QUERY, 0, 0, 32767, 32767, 1'b1, 0, 1'b0);
    add_row(ACT_QUERY, 0, 0, HALF_Q, -HALF_Q, 1'b1, 0, 1'b0);
    add_row(ACT_QUERY, 0, 0, -HALF_Q, HALF_Q, 1'b1, 0, 1'b0);
    add_row(ACT_QUERY, 0, 0, -HALF_Q - 1, -HALF_Q, 1'b1, 0, 1'b0);
    add_row(ACT_QUERY, 0, 0, -HALF_Q, -HALF_Q - 1, 1'b1, 0, 1'b0);
    add_row(ACT_QUERY, 0, 0, -20400, -20300, 1'b0, 0, 1'b0);
    add_row(ACT_QUERY, 0, 0, -HALF_Q + 1, -HALF_Q + 1, 1'b0, 0, 1'b0);
    add_row(ACT_LOAD, 16254, 'h7FFF, 0, 0, 1'b0, 0, 1'b0);
    add_row(ACT_LOAD, 16255, 'h0001, 0, 0, 1'b0, 0, 1'b0);
    add_row(ACT_LOAD, 16382, 'h5555, 0, 0, 1'b0, 0, 1'b0);
    add_row(ACT_LOAD, 16383, 'h8001, 0, 0, 1'b0, 0, 1'b0);
    add_row(ACT_QUERY, 0, 0, HALF_Q - 1, HALF_Q - 1, 1'b0, 0, 1'b0);
    add_row(ACT_QUERY, 0, 0, -32768, 0, 1'b1, 0, 1'b0);
    add_row(ACT_QUERY, 0, 0, 0, 32767, 1'b1, 0, 1'b0);
    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      send_request(row.act, row.idx, row.val, row.px, row.py, row.typed, row.want);
    end

    // Random phases, each on its own grid size; the last one on random sizes.
    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      if (phase > 0) begin
        drain_results();
        if (phase == NUM_PHASES - 1) begin
          phase_widths[phase] = CFG_W'($urandom);
          phase_heights[phase] = CFG_W'($urandom);
        end
        write_config(CFG_GRID_WIDTH, phase_widths[phase]);
        write_config(CFG_GRID_HEIGHT, phase_heights[phase]);
      end
      w_use = grid_size(grid_width_reg, DEF_MAX_COLUMNS);
      h_use = grid_size(grid_height_reg, DEF_MAX_ROWS);
      phase_end = items_sent + PHASE_ITEMS;
      while (items_sent < phase_end) begin
        case ($urandom_range(0, 9))
          0: load_random(IDX_W'($urandom));
          1: query_at(stray_pos(), stray_pos());
          2: query_at(POS_W'($urandom), POS_W'($urandom));
          default: query_at(interior_pos(w_use), interior_pos(h_use));
        endcase
        if ($urandom_range(0, 199) == 0) drain_results();
      end
    end

    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("** heightmap_bilinear_sampler_unit: PASSED **");
    end else begin
      $display("** heightmap_bilinear_sampler_unit: FAILED **");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/hbs_pkg.sv
rtl/heightmap_bilinear_sampler_unit.sv
verif/heightmap_bilinear_sampler_unit_tb.sv
